// ===== hw/rtl/ikm_pkg.sv =====
`default_nettype none

package ikm_pkg;

   localparam int TWO_PI_Q16   = 411775;
   localparam int PI_Q16       = 205887;
   localparam int HALF_PI_Q16  = 102944;
   localparam int CORDIC_K_Q30 = 652032874;
   localparam int SPEED_MAX    = 8388607;
   localparam int ATAN_MAX     = 24;
   localparam int DIV_STEPS    = 24;
   localparam int SQRT_STEPS   = 24;
   localparam int TP_OFFSET    = 41 * TWO_PI_Q16;
   localparam int RECIP_SHIFT  = 40;
   localparam logic [21:0] TWO_PI_RECIP = 22'((64'd1 << RECIP_SHIFT) / 64'(TWO_PI_Q16));

   localparam logic [29:0] ATAN_Q30 [ATAN_MAX] = '{
      30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
      30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
      30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
      30'd262144,    30'd131072,    30'd65536,     30'd32768,
      30'd16384,     30'd8192,      30'd4096,      30'd2048,
      30'd1024,      30'd512,       30'd256,       30'd128
   };

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 24;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_GAIN_U0     = 3'd0,
      CSR_PHASE_U1    = 3'd1,
      CSR_PHASE_U2    = 3'd2,
      CSR_DEATH_SPEED = 3'd3,
      CSR_RELAX_GAIN  = 3'd4
   } csr_index_type;

   localparam logic [22:0] DEATH_SPEED_RESET = 23'd3277;
   localparam logic [15:0] RELAX_GAIN_RESET  = 16'd328;

endpackage

`default_nettype wire

// ===== hw/rtl/ikm_if.sv =====
`default_nettype none

interface ikm_req_if #(parameter int POS_WIDTH = 24);
   logic                        valid;
   logic                        ready;
   logic signed [POS_WIDTH-1:0] pos_x;
   logic signed [POS_WIDTH-1:0] pos_y;
   modport source (output valid, output pos_x, output pos_y, input ready);
   modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

interface ikm_rsp_if #(parameter int POS_WIDTH = 24);
   logic                        valid;
   logic                        ready;
   logic signed [POS_WIDTH-1:0] new_x;
   logic signed [POS_WIDTH-1:0] new_y;
   logic [22:0]                 step_speed;
   logic                        alive;
   modport source (output valid, output new_x, output new_y, output step_speed,
                   output alive, input ready);
   modport sink   (input valid, input new_x, input new_y, input step_speed,
                   input alive, output ready);
endinterface

interface ikm_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [23:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ikeda_map_relax_step.sv =====
// Ikeda map relaxation step for a stream of particles.
// req_chan carries one position word (pos_x, pos_y, signed Q8.16); rsp_chan
// returns one word per request in order: new_x, new_y, step_speed, alive.
// csr_chan writes the five registers (index 0..4: gain_u0, phase_u1,
// phase_u2, death_speed, relax_gain); other indexes are dropped. Write
// registers only while no request is in flight.
// The pipeline holds 24 divider stages for u2/k, 4 phase reduction stages,
// one CORDIC stage per step, the multiply stages and 24 square root stages.
// Throughput is one word per cycle while the skid register is empty; every
// stage is a register and a new word may enter each cycle req_chan.ready is high.
// Reset clears all valid bits and loads the register defaults.
// When the receiver stalls, the response register holds its word, one more
// word lands in a skid register, and then req_chan.ready drops and the whole
// pipeline freezes in place until the response is taken.
`default_nettype none

module ikeda_map_relax_step #(
   parameter int POS_WIDTH    = 24,
   parameter int CORDIC_STEPS = 16
) (
   input  logic       clock,
   input  logic       reset,
   ikm_req_if.sink    req_chan,
   ikm_rsp_if.source  rsp_chan,
   ikm_csr_if.sink    csr_chan
);
   import ikm_pkg::*;

   localparam int PW  = POS_WIDTH;
   localparam int NC  = CORDIC_STEPS;
   localparam int SW  = 2 * PW;
   localparam int KW  = 2 * PW + 2;
   localparam int QW  = DIV_STEPS;
   localparam int TW  = 27;
   localparam int CW  = 34;
   localparam int ZW  = 33;
   localparam int PRW = PW + CW;
   localparam int AW  = PW + 5;
   localparam int NW  = AW + 24;
   localparam int DW  = PW + 15;
   localparam int GW  = DW + 17;
   localparam int RW  = DW + 2;
   localparam int VW  = 47;
   localparam int NS  = SQRT_STEPS;

   localparam logic signed [RW-1:0] POS_HI = RW'({1'b0, {(PW-1){1'b1}}});
   localparam logic signed [RW-1:0] POS_LO = -POS_HI - RW'(1);
   localparam logic signed [DW-1:0] BIG_LIM = DW'(1 << 23);
   localparam logic [19:0] TWO_PI_U = 20'(TWO_PI_Q16);
   localparam logic signed [19:0] PI_S = 20'(PI_Q16);
   localparam logic signed [19:0] HALF_PI_S = 20'(HALF_PI_Q16);

   // configuration
   logic signed [23:0] u0_ff, u1_ff, u2_ff;
   logic [22:0]        death_ff;
   logic [15:0]        gain_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         u0_ff    <= '0;
         u1_ff    <= '0;
         u2_ff    <= '0;
         death_ff <= DEATH_SPEED_RESET;
         gain_ff  <= RELAX_GAIN_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_index_type'(csr_chan.index))
            CSR_GAIN_U0:     u0_ff    <= csr_chan.data;
            CSR_PHASE_U1:    u1_ff    <= csr_chan.data;
            CSR_PHASE_U2:    u2_ff    <= csr_chan.data;
            CSR_DEATH_SPEED: death_ff <= csr_chan.data[22:0];
            CSR_RELAX_GAIN:  gain_ff  <= csr_chan.data[15:0];
            default: ;
         endcase
      end
   end

   logic rsp_v_ff, skid_v_ff, en;
   assign en = !skid_v_ff;
   assign req_chan.ready = en;

   // input and squares
   logic                 a_v_ff, b_v_ff;
   logic signed [PW-1:0] a_x_ff, a_y_ff, b_x_ff, b_y_ff;
   logic signed [SW-1:0] b_xx_ff, b_yy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff <= req_chan.valid;
         b_v_ff <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_x_ff  <= req_chan.pos_x;
         a_y_ff  <= req_chan.pos_y;
         b_x_ff  <= a_x_ff;
         b_y_ff  <= a_y_ff;
         b_xx_ff <= a_x_ff * a_x_ff;
         b_yy_ff <= a_y_ff * a_y_ff;
      end
   end

   // restoring divider for |u2| * 2^32 / k, one quotient bit per stage
   logic                 dv_ff  [QW+1];
   logic [KW-1:0]        dk_ff  [QW+1];
   logic [KW-1:0]        dp_ff  [QW+1];
   logic [QW-1:0]        dq_ff  [QW+1];
   logic                 dn_ff  [QW+1];
   logic signed [PW-1:0] dx_ff  [QW+1];
   logic signed [PW-1:0] dy_ff  [QW+1];

   logic [23:0] mag_in;
   assign mag_in = u2_ff[23] ? 24'(-u2_ff) : 24'(u2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (en) begin
         dv_ff[0] <= b_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dk_ff[0] <= (KW'(1) << 32) + KW'(unsigned'(b_xx_ff)) + KW'(unsigned'(b_yy_ff));
         dp_ff[0] <= KW'({mag_in, 8'd0});
         dq_ff[0] <= '0;
         dn_ff[0] <= u2_ff[23];
         dx_ff[0] <= b_x_ff;
         dy_ff[0] <= b_y_ff;
      end
   end

   for (genvar j = 1; j <= QW; j++) begin : g_div
      logic [KW:0] pt_in, kk_in;
      logic        ge_in;
      assign pt_in = {dp_ff[j-1], 1'b0};
      assign kk_in = {1'b0, dk_ff[j-1]};
      assign ge_in = pt_in >= kk_in;

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j] <= 1'b0;
         end else if (en) begin
            dv_ff[j] <= dv_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dk_ff[j] <= dk_ff[j-1];
            dp_ff[j] <= ge_in ? KW'(pt_in - kk_in) : KW'(pt_in);
            dq_ff[j] <= {dq_ff[j-1][QW-2:0], ge_in};
            dn_ff[j] <= dn_ff[j-1];
            dx_ff[j] <= dx_ff[j-1];
            dy_ff[j] <= dy_ff[j-1];
         end
      end
   end

   // phase and reduction into the first quadrant pair
   logic                 t1_v_ff, t2_v_ff, t3_v_ff;
   logic [25:0]          t1_tp_ff, t2_tp_ff;
   logic [6:0]           t2_qe_ff;
   logic [19:0]          t3_r_ff;
   logic signed [PW-1:0] t1_x_ff, t1_y_ff, t2_x_ff, t2_y_ff, t3_x_ff, t3_y_ff;

   logic signed [TW-1:0] sq_in, t_in, tp_in;
   logic [46:0]          recip_in;
   logic [25:0]          r0_in;
   assign sq_in    = dn_ff[QW] ? -TW'(dq_ff[QW]) : TW'(dq_ff[QW]);
   assign t_in     = TW'(u1_ff) - sq_in;
   assign tp_in    = t_in + TW'(TP_OFFSET);
   assign recip_in = 47'(t1_tp_ff) * 47'(TWO_PI_RECIP);
   assign r0_in    = t2_tp_ff - 26'(t2_qe_ff) * 26'(TWO_PI_Q16);

   logic [19:0]        r1_in;
   logic signed [19:0] r2_in, r3_in;
   logic               neg_in;
   always_comb begin
      r1_in  = (t3_r_ff >= TWO_PI_U) ? t3_r_ff - TWO_PI_U : t3_r_ff;
      r2_in  = (signed'(r1_in) > PI_S) ? signed'(r1_in) - signed'(TWO_PI_U)
                                       : signed'(r1_in);
      neg_in = 1'b0;
      r3_in  = r2_in;
      if (r2_in > HALF_PI_S) begin
         r3_in  = r2_in - PI_S;
         neg_in = 1'b1;
      end else if (r2_in < -HALF_PI_S) begin
         r3_in  = r2_in + PI_S;
         neg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_v_ff <= 1'b0;
         t2_v_ff <= 1'b0;
         t3_v_ff <= 1'b0;
      end else if (en) begin
         t1_v_ff <= dv_ff[QW];
         t2_v_ff <= t1_v_ff;
         t3_v_ff <= t2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_tp_ff <= tp_in[25:0];
         t2_tp_ff <= t1_tp_ff;
         t2_qe_ff <= recip_in[46:40];
         t3_r_ff  <= r0_in[19:0];
         t1_x_ff  <= dx_ff[QW];
         t1_y_ff  <= dy_ff[QW];
         t2_x_ff  <= t1_x_ff;
         t2_y_ff  <= t1_y_ff;
         t3_x_ff  <= t2_x_ff;
         t3_y_ff  <= t2_y_ff;
      end
   end

   // CORDIC rotation, one step per stage
   logic                 cv_ff [NC+1];
   logic signed [CW-1:0] cx_ff [NC+1];
   logic signed [CW-1:0] cy_ff [NC+1];
   logic signed [ZW-1:0] cz_ff [NC+1];
   logic                 cn_ff [NC+1];
   logic signed [PW-1:0] px_ff [NC+1];
   logic signed [PW-1:0] py_ff [NC+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff[0] <= 1'b0;
      end else if (en) begin
         cv_ff[0] <= t3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff[0] <= CW'(CORDIC_K_Q30);
         cy_ff[0] <= '0;
         cz_ff[0] <= ZW'(r3_in) <<< 14;
         cn_ff[0] <= neg_in;
         px_ff[0] <= t3_x_ff;
         py_ff[0] <= t3_y_ff;
      end
   end

   for (genvar j = 1; j <= NC; j++) begin : g_cordic
      logic signed [CW-1:0] xs_in, ys_in;
      logic [ZW-1:0]        at_in;
      assign xs_in = cx_ff[j-1] >>> (j - 1);
      assign ys_in = cy_ff[j-1] >>> (j - 1);
      assign at_in = ZW'(ATAN_Q30[j-1]);

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[j] <= 1'b0;
         end else if (en) begin
            cv_ff[j] <= cv_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            if (!cz_ff[j-1][ZW-1]) begin
               cx_ff[j] <= cx_ff[j-1] - ys_in;
               cy_ff[j] <= cy_ff[j-1] + xs_in;
               cz_ff[j] <= cz_ff[j-1] - signed'(at_in);
            end else begin
               cx_ff[j] <= cx_ff[j-1] + ys_in;
               cy_ff[j] <= cy_ff[j-1] - xs_in;
               cz_ff[j] <= cz_ff[j-1] + signed'(at_in);
            end
            cn_ff[j] <= cn_ff[j-1];
            px_ff[j] <= px_ff[j-1];
            py_ff[j] <= py_ff[j-1];
         end
      end
   end

   // image point, step and relaxed position
   logic signed [CW-1:0]  c_in, s_in;
   assign c_in = cn_ff[NC] ? -cx_ff[NC] : cx_ff[NC];
   assign s_in = cn_ff[NC] ? -cy_ff[NC] : cy_ff[NC];

   logic                  m1_v_ff, m2_v_ff, m3_v_ff, m4_v_ff, m5_v_ff;
   logic signed [PRW-1:0] m1_xc_ff, m1_ys_ff, m1_xs_ff, m1_yc_ff;
   logic signed [AW-1:0]  m2_a_ff, m2_b_ff;
   logic signed [NW-1:0]  m3_pa_ff, m3_pb_ff;
   logic signed [DW-1:0]  m4_dx_ff, m4_dy_ff;
   logic                  m5_big_ff;
   logic signed [47:0]    m5_dx2_ff, m5_dy2_ff;
   logic signed [GW-1:0]  m5_gx_ff, m5_gy_ff;
   logic signed [PW-1:0]  m1_x_ff, m1_y_ff, m2_x_ff, m2_y_ff, m3_x_ff, m3_y_ff;
   logic signed [PW-1:0]  m4_x_ff, m4_y_ff, m5_x_ff, m5_y_ff;

   logic signed [PRW:0]   da_in, db_in;
   logic signed [DW-1:0]  nx_in, ny_in;
   logic signed [23:0]    dxl_in, dyl_in;
   logic signed [16:0]    g_in;
   logic signed [RW-1:0]  rx_in, ry_in;
   assign da_in  = (PRW+1)'(m1_xc_ff) - (PRW+1)'(m1_ys_ff);
   assign db_in  = (PRW+1)'(m1_xs_ff) - (PRW+1)'(m1_yc_ff);
   assign nx_in  = DW'(signed'(m3_pa_ff[NW-1:16])) + DW'(65536);
   assign ny_in  = DW'(signed'(m3_pb_ff[NW-1:16]));
   assign dxl_in = m4_dx_ff[23:0];
   assign dyl_in = m4_dy_ff[23:0];
   assign g_in   = signed'({1'b0, gain_ff});
   assign rx_in  = RW'(m5_x_ff) + RW'(signed'(m5_gx_ff[GW-1:16]));
   assign ry_in  = RW'(m5_y_ff) + RW'(signed'(m5_gy_ff[GW-1:16]));

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff <= 1'b0;
         m2_v_ff <= 1'b0;
         m3_v_ff <= 1'b0;
         m4_v_ff <= 1'b0;
         m5_v_ff <= 1'b0;
      end else if (en) begin
         m1_v_ff <= cv_ff[NC];
         m2_v_ff <= m1_v_ff;
         m3_v_ff <= m2_v_ff;
         m4_v_ff <= m3_v_ff;
         m5_v_ff <= m4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_xc_ff  <= px_ff[NC] * c_in;
         m1_ys_ff  <= py_ff[NC] * s_in;
         m1_xs_ff  <= px_ff[NC] * s_in;
         m1_yc_ff  <= py_ff[NC] * c_in;
         m2_a_ff   <= da_in[PRW:30];
         m2_b_ff   <= db_in[PRW:30];
         m3_pa_ff  <= u0_ff * m2_a_ff;
         m3_pb_ff  <= u0_ff * m2_b_ff;
         m4_dx_ff  <= nx_in - DW'(m3_x_ff);
         m4_dy_ff  <= ny_in - DW'(m3_y_ff);
         m5_big_ff <= (m4_dx_ff >= BIG_LIM) || (m4_dx_ff <= -BIG_LIM) ||
                      (m4_dy_ff >= BIG_LIM) || (m4_dy_ff <= -BIG_LIM);
         m5_dx2_ff <= dxl_in * dxl_in;
         m5_dy2_ff <= dyl_in * dyl_in;
         m5_gx_ff  <= g_in * m4_dx_ff;
         m5_gy_ff  <= g_in * m4_dy_ff;
         m1_x_ff   <= px_ff[NC];
         m1_y_ff   <= py_ff[NC];
         m2_x_ff   <= m1_x_ff;
         m2_y_ff   <= m1_y_ff;
         m3_x_ff   <= m2_x_ff;
         m3_y_ff   <= m2_y_ff;
         m4_x_ff   <= m3_x_ff;
         m4_y_ff   <= m3_y_ff;
         m5_x_ff   <= m4_x_ff;
         m5_y_ff   <= m4_y_ff;
      end
   end

   // bitwise square root of dx^2 + dy^2, one result bit per stage
   logic                 sv_ff   [NS+1];
   logic [VW-1:0]        sr_ff   [NS+1];
   logic [VW:0]          sres_ff [NS+1];
   logic                 sbig_ff [NS+1];
   logic signed [PW-1:0] sx_ff   [NS+1];
   logic signed [PW-1:0] sy_ff   [NS+1];
   logic signed [PW-1:0] snx_ff  [NS+1];
   logic signed [PW-1:0] sny_ff  [NS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff[0] <= 1'b0;
      end else if (en) begin
         sv_ff[0] <= m5_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sr_ff[0]   <= VW'(m5_dx2_ff[45:0]) + VW'(m5_dy2_ff[45:0]);
         sres_ff[0] <= '0;
         sbig_ff[0] <= m5_big_ff;
         sx_ff[0]   <= m5_x_ff;
         sy_ff[0]   <= m5_y_ff;
         snx_ff[0]  <= (rx_in > POS_HI) ? PW'(POS_HI) :
                       (rx_in < POS_LO) ? PW'(POS_LO) : PW'(rx_in);
         sny_ff[0]  <= (ry_in > POS_HI) ? PW'(POS_HI) :
                       (ry_in < POS_LO) ? PW'(POS_LO) : PW'(ry_in);
      end
   end

   for (genvar j = 1; j <= NS; j++) begin : g_sqrt
      logic [VW:0] bit_in, trial_in;
      logic        ge_in;
      assign bit_in   = (VW+1)'(1) << (2 * (NS - j));
      assign trial_in = sres_ff[j-1] + bit_in;
      assign ge_in    = {1'b0, sr_ff[j-1]} >= trial_in;

      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[j] <= 1'b0;
         end else if (en) begin
            sv_ff[j] <= sv_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sr_ff[j]   <= ge_in ? VW'({1'b0, sr_ff[j-1]} - trial_in) : sr_ff[j-1];
            sres_ff[j] <= ge_in ? (sres_ff[j-1] >> 1) + bit_in : sres_ff[j-1] >> 1;
            sbig_ff[j] <= sbig_ff[j-1];
            sx_ff[j]   <= sx_ff[j-1];
            sy_ff[j]   <= sy_ff[j-1];
            snx_ff[j]  <= snx_ff[j-1];
            sny_ff[j]  <= sny_ff[j-1];
         end
      end
   end

   // final select, response register and skid
   logic [22:0]          speed_in;
   logic                 alive_in;
   logic signed [PW-1:0] fx_in, fy_in;
   assign speed_in = (sbig_ff[NS] || sres_ff[NS][23:0] > 24'(SPEED_MAX)) ?
                     23'(SPEED_MAX) : sres_ff[NS][22:0];
   assign alive_in = speed_in >= death_ff;
   assign fx_in    = alive_in ? snx_ff[NS] : sx_ff[NS];
   assign fy_in    = alive_in ? sny_ff[NS] : sy_ff[NS];

   logic signed [PW-1:0] rsp_x_ff, rsp_y_ff, skid_x_ff, skid_y_ff;
   logic [22:0]          rsp_speed_ff, skid_speed_ff;
   logic                 rsp_alive_ff, skid_alive_ff;
   logic                 take_in, last_in;
   assign take_in = rsp_v_ff && rsp_chan.ready;
   assign last_in = en && sv_ff[NS];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (take_in || !rsp_v_ff) begin
         rsp_v_ff  <= skid_v_ff || last_in;
         skid_v_ff <= 1'b0;
      end else if (last_in) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take_in || !rsp_v_ff) begin
         if (skid_v_ff) begin
            rsp_x_ff     <= skid_x_ff;
            rsp_y_ff     <= skid_y_ff;
            rsp_speed_ff <= skid_speed_ff;
            rsp_alive_ff <= skid_alive_ff;
         end else begin
            rsp_x_ff     <= fx_in;
            rsp_y_ff     <= fy_in;
            rsp_speed_ff <= speed_in;
            rsp_alive_ff <= alive_in;
         end
      end else if (last_in) begin
         skid_x_ff     <= fx_in;
         skid_y_ff     <= fy_in;
         skid_speed_ff <= speed_in;
         skid_alive_ff <= alive_in;
      end
   end

   assign rsp_chan.valid      = rsp_v_ff;
   assign rsp_chan.new_x      = rsp_x_ff;
   assign rsp_chan.new_y      = rsp_y_ff;
   assign rsp_chan.step_speed = rsp_speed_ff;
   assign rsp_chan.alive      = rsp_alive_ff;

   a_skid_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> rsp_v_ff)
      else $error("skid word without response word");

   a_stall_to_skid: assert property (@(posedge clock) disable iff (reset)
      (rsp_v_ff && !rsp_chan.ready && last_in) |=> skid_v_ff)
      else $error("word dropped at stalled output");

   a_skid_blocks_req: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> !req_chan.ready)
      else $error("request taken while skid full");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_v_ff && !skid_v_ff))
      else $error("output not empty after reset");

endmodule

`default_nettype wire
